// File: hdl/segment_id_block_map_allocator_unit_assert.svh
// Assertion macros used by the allocator checker.
`ifndef SEGMENT_ID_BLOCK_MAP_ALLOCATOR_UNIT_ASSERT_SVH
`define SEGMENT_ID_BLOCK_MAP_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define SBMA_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed in the same cycle");

// Next-cycle implication, checked while out of reset.
`define SBMA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed in the next cycle");

`endif

// File: hdl/sbma_pkg.sv
// Shared types, codes and helpers of the block map allocator.
`timescale 1ns / 1ps
package sbma_pkg;
	localparam int MapEntriesDef = 256;
	localparam int BlockBytesDef = 16;

	localparam int OP_W    = 2;
	localparam int SIZE_W  = 13;
	localparam int ALIGN_W = 4;
	localparam int BIDX_W  = 8;
	localparam int STAT_W  = 2;
	localparam int RIDX_W  = 8;
	localparam int CNTO_W  = 9;
	localparam int ID_W    = 8;
	localparam int QUO_W   = 14;
	localparam int WIDE_W  = 16;

	typedef logic [ID_W-1:0] seg_id_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
	localparam logic [OP_W-1:0] OP_RESIZE = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOSPACE  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NULL     = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOTALLOC = 2'd3;

	localparam seg_id_t ID_FREE = '0;

	// Step past zero and the right neighbor; two steps always suffice.
	function automatic seg_id_t pick_id(seg_id_t left, seg_id_t right);
		seg_id_t c;
		c = left + 8'd1;
		for (int i = 0; i < 2; i++) begin
			if (c == right || c == ID_FREE) c = c + 8'd1;
		end
		return c;
	endfunction
endpackage

// File: hdl/sbma_ceil_div.sv
// Ceiling division of a byte size by the block size, by reciprocal multiplication.
`timescale 1ns / 1ps
module sbma_ceil_div #(
	parameter int BLOCK_BYTES = sbma_pkg::BlockBytesDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [sbma_pkg::SIZE_W-1:0]  size_bytes,
	output sbma_pkg::div_stat_t          stat,
	output logic [sbma_pkg::QUO_W-1:0]   quotient
);
	import sbma_pkg::*;

	// floor(n * RECIP / 2^SH) equals floor(n / BLOCK_BYTES) for every n below 2^QUO_W
	localparam int SH    = QUO_W + $clog2(BLOCK_BYTES);
	localparam int RECIP = (2 ** SH + BLOCK_BYTES - 1) / BLOCK_BYTES;
	localparam int PW    = SH + QUO_W;

	logic [QUO_W-1:0] num;
	logic [PW-1:0]    prod;
	logic [QUO_W-1:0] quo_q;
	logic             done_q;

	// round up: add block size minus one
	assign num  = QUO_W'(size_bytes) + QUO_W'(BLOCK_BYTES - 1);
	assign prod = PW'(num) * PW'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= start;
			if (start) quo_q <= prod[SH +: QUO_W];
		end
	end

	assign stat.busy = 1'b0;
	assign stat.done = done_q;
	assign quotient  = quo_q;
endmodule

// File: hdl/segment_id_block_map_allocator_unit.sv
// Top level of the segment-id block map allocator (next fit, one region).
//
//   channel  dir  handshake             payload
//   request  in   in_valid / in_stall   opcode size_bytes align_log2 block_index index_valid
//   result   out  out_valid / out_stall status result_index moved copy_blocks blocks_used
//
// One request at a time. A request first has its size rounded, then reads and
// writes map entries; every entry read takes a read state and a check state
// (single registered read port). A worst-case allocate walks about 2 * MAP_ENTRIES
// entries. After reset the map is swept to zero, one entry per cycle, with in_stall
// high. A stalled result is held in the output register; the sequencer
// waits at its end until the register is free.
`timescale 1ns / 1ps
module segment_id_block_map_allocator_unit #(
	parameter int MAP_ENTRIES = sbma_pkg::MapEntriesDef,
	parameter int BLOCK_BYTES = sbma_pkg::BlockBytesDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sbma_pkg::OP_W-1:0]     opcode,
	input  logic [sbma_pkg::SIZE_W-1:0]   size_bytes,
	input  logic [sbma_pkg::ALIGN_W-1:0]  align_log2,
	input  logic [sbma_pkg::BIDX_W-1:0]   block_index,
	input  logic                          index_valid,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sbma_pkg::STAT_W-1:0]   status,
	output logic [sbma_pkg::RIDX_W-1:0]   result_index,
	output logic                          moved,
	output logic [sbma_pkg::CNTO_W-1:0]   copy_blocks,
	output logic [sbma_pkg::CNTO_W-1:0]   blocks_used
);
	import sbma_pkg::*;

	localparam int IDX_W = $clog2(MAP_ENTRIES);
	localparam int XW    = $clog2(MAP_ENTRIES + 1);
	localparam int WW    = WIDE_W;

	// sequencer states
	localparam logic [4:0] S_CLEAR  = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_DIV    = 5'd2;
	localparam logic [4:0] S_OWN    = 5'd3;
	localparam logic [4:0] S_CL_RD  = 5'd4;
	localparam logic [4:0] S_CL_CHK = 5'd5;
	localparam logic [4:0] S_G1_RD  = 5'd6;
	localparam logic [4:0] S_G1_CHK = 5'd7;
	localparam logic [4:0] S_G2_RD  = 5'd8;
	localparam logic [4:0] S_G2_CHK = 5'd9;
	localparam logic [4:0] S_NX_RD  = 5'd10;
	localparam logic [4:0] S_NX_CHK = 5'd11;
	localparam logic [4:0] S_LF_RD  = 5'd12;
	localparam logic [4:0] S_LF_CHK = 5'd13;
	localparam logic [4:0] S_RT_RD  = 5'd14;
	localparam logic [4:0] S_RT_CHK = 5'd15;
	localparam logic [4:0] S_FILL   = 5'd16;
	localparam logic [4:0] S_C_INIT = 5'd17;
	localparam logic [4:0] S_C_TOP  = 5'd18;
	localparam logic [4:0] S_C_CHK  = 5'd19;
	localparam logic [4:0] S_C_RUN  = 5'd20;
	localparam logic [4:0] S_C_RCHK = 5'd21;
	localparam logic [4:0] S_DONE   = 5'd22;

	logic [4:0]         state_q;

	// request fields
	logic [OP_W-1:0]    op_q;
	logic [SIZE_W-1:0]  size_q;
	logic [ALIGN_W-1:0] align_q;
	logic [IDX_W-1:0]   bi_q;
	logic               vld_q;
	logic               bi_ok_q;
	logic [QUO_W-1:0]   need_q;

	// walk state
	logic [XW-1:0]      x_q;
	logic [XW-1:0]      y_q;
	logic [XW-1:0]      x0_q;
	logic [XW-1:0]      fill_hi_q;
	logic               wrapped_q;
	seg_id_t            id_q;
	seg_id_t            left_q;
	seg_id_t            fval_q;
	logic               ctx_claim_q;
	logic               ret_claim_q;
	logic               reloc_q;
	logic [XW-1:0]      len_q;
	logic [XW-1:0]      old_len_q;

	// allocator state
	logic [IDX_W-1:0]   sp_q;
	logic [XW-1:0]      used_q;

	// result in progress
	logic [STAT_W-1:0]  r_status_q;
	logic [IDX_W-1:0]   r_res_q;
	logic               r_moved_q;
	logic [XW-1:0]      r_copy_q;

	// output register
	logic               out_valid_q;
	logic [STAT_W-1:0]  o_status_q;
	logic [RIDX_W-1:0]  o_res_q;
	logic               o_moved_q;
	logic [CNTO_W-1:0]  o_copy_q;
	logic [CNTO_W-1:0]  o_used_q;

	// block map memory
	seg_id_t            map_mem [MAP_ENTRIES];
	seg_id_t            rd_data_q;
	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W-1:0]   wr_addr;
	seg_id_t            wr_data;
	logic               wr_en;

	// size rounding
	logic               div_start;
	div_stat_t          div_stat;
	logic [QUO_W-1:0]   div_quo;

	logic               accept;

	// address arithmetic in one wide width; the byte alignment check in 32 bits
	logic [WW-1:0]      w_x, w_bi, w_need, w_m, span, xy, xn, free_cnt, sp_t, sp_n;
	logic               x_lt_m, dist_lt_rb, xy_lt_m, y_lt_need, xn_lt_m, wrap_stop;
	logic [31:0]        byte_addr, amask;
	logic               aligned;

	sbma_ceil_div #(.BLOCK_BYTES(BLOCK_BYTES)) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.size_bytes (size_bytes),
		.stat       (div_stat),
		.quotient   (div_quo)
	);

	assign accept    = in_valid && (state_q == S_IDLE);
	assign div_start = accept;
	assign in_stall  = (state_q != S_IDLE);

	assign w_x       = WW'(x_q);
	assign w_bi      = WW'(bi_q);
	assign w_need    = WW'(need_q);
	assign w_m       = WW'(MAP_ENTRIES);
	assign span      = w_x - w_bi;
	assign xy        = w_x + WW'(y_q);
	assign xn        = w_x + w_need;
	assign free_cnt  = w_m - WW'(used_q);
	assign x_lt_m    = w_x < w_m;
	assign dist_lt_rb = span < w_need;
	assign xy_lt_m   = xy < w_m;
	assign y_lt_need = WW'(y_q) < w_need;
	assign xn_lt_m   = xn < w_m;
	assign wrap_stop = wrapped_q && (w_x > WW'(sp_q));

	// start byte of a candidate run against the requested alignment
	assign byte_addr = 32'(x_q) * 32'(BLOCK_BYTES);
	assign amask     = (align_q == '0) ? '0 : ((32'd1 << align_q) - 32'd1);
	assign aligned   = (byte_addr & amask) == '0;

	// next search pointer: start + blocks - 2, modulo the map size
	assign sp_t = xn + w_m - WW'(2);
	assign sp_n = (sp_t >= w_m) ? sp_t - w_m : sp_t;

	always_comb begin
		unique case (state_q)
			S_DIV:   rd_addr = bi_q;
			S_C_RUN: rd_addr = xy[IDX_W-1:0];
			S_RT_RD: rd_addr = xn[IDX_W-1:0];
			S_LF_RD: rd_addr = ctx_claim_q ? x_q[IDX_W-1:0] - IDX_W'(1) : bi_q - IDX_W'(1);
			default: rd_addr = x_q[IDX_W-1:0];
		endcase
	end

	always_comb begin
		wr_addr = x_q[IDX_W-1:0];
		wr_data = ID_FREE;
		wr_en   = 1'b0;
		unique case (state_q)
			S_CLEAR:  wr_en = 1'b1;
			S_CL_CHK: wr_en = (rd_data_q == id_q);
			S_FILL: begin
				wr_en   = 1'b1;
				wr_data = fval_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) map_mem[wr_addr] <= wr_data;
		rd_data_q <= map_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			op_q        <= '0;
			size_q      <= '0;
			align_q     <= '0;
			bi_q        <= '0;
			vld_q       <= 1'b0;
			bi_ok_q     <= 1'b0;
			need_q      <= '0;
			x_q         <= '0;
			y_q         <= '0;
			x0_q        <= '0;
			fill_hi_q   <= '0;
			wrapped_q   <= 1'b0;
			id_q        <= ID_FREE;
			left_q      <= ID_FREE;
			fval_q      <= ID_FREE;
			ctx_claim_q <= 1'b0;
			ret_claim_q <= 1'b0;
			reloc_q     <= 1'b0;
			len_q       <= '0;
			old_len_q   <= '0;
			sp_q        <= IDX_W'(MAP_ENTRIES - 1);
			used_q      <= '0;
			r_status_q  <= STAT_OK;
			r_res_q     <= '0;
			r_moved_q   <= 1'b0;
			r_copy_q    <= '0;
			out_valid_q <= 1'b0;
			o_status_q  <= STAT_OK;
			o_res_q     <= '0;
			o_moved_q   <= 1'b0;
			o_copy_q    <= '0;
			o_used_q    <= '0;
		end else begin
			// drop the result once taken; the final state reloads it itself
			if (out_valid_q && !out_stall && state_q != S_DONE) out_valid_q <= 1'b0;

			unique case (state_q)
				S_CLEAR: begin
					x_q <= x_q + XW'(1);
					if (w_x == w_m - WW'(1)) state_q <= S_IDLE;
				end

				S_IDLE: begin
					if (accept) begin
						op_q       <= opcode;
						size_q     <= size_bytes;
						align_q    <= align_log2;
						bi_q       <= IDX_W'(block_index);
						vld_q      <= index_valid;
						bi_ok_q    <= WW'(block_index) < w_m;
						r_status_q <= STAT_OK;
						r_res_q    <= '0;
						r_moved_q  <= 1'b0;
						r_copy_q   <= '0;
						reloc_q    <= 1'b0;
						state_q    <= S_DIV;
					end
				end

				S_DIV: begin
					if (div_stat.done) begin
						need_q <= div_quo;
						case (op_q)
							OP_ALLOC: begin
								if (size_q == '0) begin
									r_status_q <= STAT_NULL;
									state_q    <= S_DONE;
								end else begin
									state_q <= S_C_INIT;
								end
							end
							OP_FREE: begin
								if (!vld_q) begin
									state_q <= S_DONE;
								end else if (!bi_ok_q) begin
									r_status_q <= STAT_NOTALLOC;
									state_q    <= S_DONE;
								end else begin
									state_q <= S_OWN;
								end
							end
							OP_RESIZE: begin
								if (!vld_q) begin
									// null resize is a plain allocate
									align_q <= '0;
									if (size_q == '0) begin
										r_status_q <= STAT_NULL;
										state_q    <= S_DONE;
									end else begin
										state_q <= S_C_INIT;
									end
								end else if (!bi_ok_q) begin
									r_status_q <= STAT_NOTALLOC;
									state_q    <= S_DONE;
								end else begin
									state_q <= S_OWN;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end

				S_OWN: begin
					id_q        <= rd_data_q;
					x_q         <= XW'(bi_q);
					len_q       <= '0;
					ret_claim_q <= 1'b0;
					if (rd_data_q == ID_FREE) begin
						r_status_q <= STAT_NOTALLOC;
						state_q    <= S_DONE;
					end else if (op_q == OP_FREE) begin
						state_q <= S_CL_RD;
					end else if (size_q == '0) begin
						r_status_q <= STAT_NULL;
						state_q    <= S_CL_RD;
					end else begin
						state_q <= S_G1_RD;
					end
				end

				// clear the run of id_q from x_q onward
				S_CL_RD: begin
					if (x_lt_m) begin
						state_q <= S_CL_CHK;
					end else if (ret_claim_q) begin
						old_len_q <= len_q;
						state_q   <= S_C_INIT;
					end else begin
						state_q <= S_DONE;
					end
				end

				S_CL_CHK: begin
					if (rd_data_q == id_q) begin
						used_q  <= used_q - XW'(1);
						len_q   <= len_q + XW'(1);
						x_q     <= x_q + XW'(1);
						state_q <= S_CL_RD;
					end else if (ret_claim_q) begin
						old_len_q <= len_q;
						state_q   <= S_C_INIT;
					end else begin
						state_q <= S_DONE;
					end
				end

				// resize: walk the segment up to the new length
				S_G1_RD: begin
					if (x_lt_m && dist_lt_rb) begin
						state_q <= S_G1_CHK;
					end else if (!dist_lt_rb) begin
						// shrink in place: cut the tail
						x0_q    <= x_q;
						r_res_q <= bi_q;
						state_q <= S_CL_RD;
					end else begin
						x0_q    <= x_q;
						state_q <= S_G2_RD;
					end
				end

				S_G1_CHK: begin
					if (rd_data_q == id_q) begin
						x_q     <= x_q + XW'(1);
						state_q <= S_G1_RD;
					end else begin
						x0_q    <= x_q;
						state_q <= S_G2_RD;
					end
				end

				// resize: extend over the free blocks that follow
				S_G2_RD: begin
					if (x_lt_m && dist_lt_rb) begin
						state_q <= S_G2_CHK;
					end else if (!dist_lt_rb) begin
						used_q    <= used_q + (x_q - x0_q);
						r_res_q   <= bi_q;
						fill_hi_q <= x_q;
						if (x_lt_m) begin
							state_q <= S_NX_RD;
						end else begin
							x_q     <= x0_q;
							fval_q  <= id_q;
							state_q <= S_FILL;
						end
					end else begin
						x_q         <= XW'(bi_q);
						align_q     <= '0;
						ret_claim_q <= 1'b1;
						reloc_q     <= 1'b1;
						state_q     <= S_CL_RD;
					end
				end

				S_G2_CHK: begin
					if (rd_data_q == ID_FREE) begin
						x_q     <= x_q + XW'(1);
						state_q <= S_G2_RD;
					end else begin
						// no room in place: free and allocate again
						x_q         <= XW'(bi_q);
						align_q     <= '0;
						ret_claim_q <= 1'b1;
						reloc_q     <= 1'b1;
						state_q     <= S_CL_RD;
					end
				end

				S_NX_RD: state_q <= S_NX_CHK;

				S_NX_CHK: begin
					if (rd_data_q == id_q) begin
						// would merge with the next segment: recolor the whole run
						ctx_claim_q <= 1'b0;
						state_q     <= S_LF_RD;
					end else begin
						x_q     <= x0_q;
						fval_q  <= id_q;
						state_q <= S_FILL;
					end
				end

				S_LF_RD: state_q <= S_LF_CHK;

				S_LF_CHK: begin
					if (ctx_claim_q) begin
						left_q  <= (x_q == '0) ? ID_FREE : rd_data_q;
						state_q <= S_RT_RD;
					end else begin
						fval_q  <= pick_id((bi_q == '0) ? ID_FREE : rd_data_q, id_q);
						x_q     <= XW'(bi_q);
						state_q <= S_FILL;
					end
				end

				S_RT_RD: state_q <= S_RT_CHK;

				S_RT_CHK: begin
					fval_q    <= pick_id(left_q, xn_lt_m ? rd_data_q : ID_FREE);
					fill_hi_q <= XW'(xn);
					state_q   <= S_FILL;
				end

				S_FILL: begin
					x_q <= x_q + XW'(1);
					if (w_x + WW'(1) == WW'(fill_hi_q)) state_q <= S_DONE;
				end

				// next-fit search
				S_C_INIT: begin
					x_q       <= XW'(sp_q) + XW'(1);
					y_q       <= '0;
					wrapped_q <= 1'b0;
					if (need_q == '0 || w_need > free_cnt) begin
						r_status_q <= STAT_NOSPACE;
						state_q    <= S_DONE;
					end else begin
						state_q <= S_C_TOP;
					end
				end

				S_C_TOP: begin
					if (!x_lt_m) begin
						if (wrapped_q) begin
							r_status_q <= STAT_NOSPACE;
							state_q    <= S_DONE;
						end else begin
							wrapped_q <= 1'b1;
							x_q       <= '0;
						end
					end else if (wrap_stop) begin
						r_status_q <= STAT_NOSPACE;
						state_q    <= S_DONE;
					end else if (!aligned) begin
						x_q <= x_q + XW'(1);
					end else begin
						state_q <= S_C_CHK;
					end
				end

				S_C_CHK: begin
					if (rd_data_q != ID_FREE) begin
						x_q     <= x_q + XW'(1);
						state_q <= S_C_TOP;
					end else begin
						y_q     <= '0;
						state_q <= S_C_RUN;
					end
				end

				S_C_RUN: begin
					if (y_lt_need && xy_lt_m) begin
						state_q <= S_C_RCHK;
					end else if (!y_lt_need) begin
						// found: claim it
						r_res_q     <= x_q[IDX_W-1:0];
						sp_q        <= IDX_W'(sp_n);
						used_q      <= used_q + XW'(need_q);
						ctx_claim_q <= 1'b1;
						if (reloc_q) begin
							r_moved_q <= 1'b1;
							r_copy_q  <= old_len_q;
						end
						state_q <= S_LF_RD;
					end else begin
						x_q     <= x_q + y_q;
						state_q <= S_C_TOP;
					end
				end

				S_C_RCHK: begin
					if (rd_data_q == ID_FREE) begin
						y_q <= y_q + XW'(1);
					end else begin
						x_q     <= x_q + y_q;
						state_q <= S_C_TOP;
					end
					if (rd_data_q == ID_FREE) state_q <= S_C_RUN;
				end

				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						o_status_q  <= r_status_q;
						o_res_q     <= RIDX_W'(r_res_q);
						o_moved_q   <= r_moved_q;
						o_copy_q    <= CNTO_W'(r_copy_q);
						o_used_q    <= CNTO_W'(used_q);
						state_q     <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = o_status_q;
	assign result_index = o_res_q;
	assign moved        = o_moved_q;
	assign copy_blocks  = o_copy_q;
	assign blocks_used  = o_used_q;
endmodule

// File: hdl/sbma_checker.sv
// Port-level checks of the allocator and their binding.
`timescale 1ns / 1ps
`include "segment_id_block_map_allocator_unit_assert.svh"
module sbma_checker #(
	parameter int MAP_ENTRIES = sbma_pkg::MapEntriesDef
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [sbma_pkg::STAT_W-1:0]   status,
	input logic [sbma_pkg::RIDX_W-1:0]   result_index,
	input logic                          moved,
	input logic [sbma_pkg::CNTO_W-1:0]   copy_blocks,
	input logic [sbma_pkg::CNTO_W-1:0]   blocks_used
);
	import sbma_pkg::*;

	// a held result must stay valid and keep its status, index and usage
	`SBMA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(result_index) && $stable(blocks_used))
	// one request at a time: busy right after an accept
	`SBMA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	// failures carry no start block and no move
	`SBMA_ASSERT_IMPLY(a_fail_clean, out_valid && status != STAT_OK, result_index == '0 && !moved && copy_blocks == '0)
	// copy length only on a move
	`SBMA_ASSERT_IMPLY(a_copy_only_moved, out_valid && !moved, copy_blocks == '0)
	// usage never exceeds the map
	`SBMA_ASSERT_IMPLY(a_used_bound, out_valid, 32'(blocks_used) <= MAP_ENTRIES)
endmodule

bind segment_id_block_map_allocator_unit sbma_checker #(.MAP_ENTRIES(MAP_ENTRIES)) u_sbma_checker (.*);
